/* rtl/trpf_pkg.sv */
// Shared types, codes and defaults for the triac phase fire controller.
package trpf_pkg;

    // Default timer and compare width
    localparam int TIMER_WIDTH_DEF = 16;

    // Field widths fixed by the interface
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int TICKS_W      = 16;
    localparam int PPC_W        = 2;
    localparam int PULSE_CNT_W  = 3;
    localparam int CROSS_CNT_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSES_PER = 2'd2;

    // Configuration reset values
    localparam logic [TICKS_W-1:0] PULSE_HIGH_RST = 16'd250;
    localparam logic [TICKS_W-1:0] PULSE_LOW_RST  = 16'd50;
    localparam logic [PPC_W-1:0]   PULSES_PER_RST = 2'd3;

    // Pulse counter value that marks a stopped train
    localparam logic [PULSE_CNT_W-1:0] PULSES_STOPPED = 3'd4;

    // Input action codes
    typedef enum logic {
        ACT_TICK     = 1'b0,
        ACT_CROSSING = 1'b1
    } trpf_action_t;

    // One update step handed to the timer units
    typedef struct packed {
        logic fire;      // commit this transaction to state
        logic crossing;  // zero crossing, else timer tick
        logic enable;    // firing enable
        logic stop_ok;   // servo stop allowed
    } trpf_step_t;

    // Post-update gate status
    typedef struct packed {
        logic                   level;
        logic [PULSE_CNT_W-1:0] pulses;
    } trpf_gate_stat_t;

endpackage

/* rtl/trpf_gate.sv */
// Gate timer: phase delay wait and gate pulse train generation.
module trpf_gate import trpf_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  trpf_step_t             step,
    input  logic [TICKS_W-1:0]     phase_delay,
    input  logic [TICKS_W-1:0]     pulse_high_ticks,
    input  logic [TICKS_W-1:0]     pulse_low_ticks,
    input  logic [PPC_W-1:0]       pulses_per_half_cycle,
    output trpf_gate_stat_t        stat_next
);

    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [TIMER_WIDTH-1:0] compare_reg, compare_next;
    logic                   armed_reg, armed_next;
    logic                   phase_high_reg, phase_high_next;
    logic                   level_reg, level_next;
    logic [PULSE_CNT_W-1:0] pulses_reg, pulses_next;

    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [PULSE_CNT_W-1:0] pulses_inc;
    logic                   event_hit;

    assign timer_inc  = timer_reg + 1'b1;
    assign pulses_inc = pulses_reg + 1'b1;
    assign event_hit  = armed_reg && (timer_inc == compare_reg);

    // Compute next gate state for one transaction
    always_comb begin
        timer_next      = timer_reg;
        compare_next    = compare_reg;
        armed_next      = armed_reg;
        phase_high_next = phase_high_reg;
        level_next      = level_reg;
        pulses_next     = pulses_reg;
        if (step.crossing) begin
            if (pulses_reg == PULSES_STOPPED) begin
                pulses_next = '0;
            end
            phase_high_next = 1'b0;
            timer_next      = '0;
            compare_next    = TIMER_WIDTH'(phase_delay);
            if (step.enable) begin
                armed_next = 1'b1;
            end
        end else begin
            timer_next = timer_inc;
            if (event_hit) begin
                if (!phase_high_reg) begin
                    // Start a pulse unless the train has stopped
                    if (pulses_reg < PULSES_STOPPED) begin
                        if (step.enable) begin
                            level_next = 1'b1;
                        end
                        phase_high_next = 1'b1;
                        timer_next      = '0;
                        compare_next    = TIMER_WIDTH'(pulse_high_ticks);
                    end
                end else begin
                    // End a pulse and count it
                    pulses_next     = pulses_inc;
                    timer_next      = '0;
                    compare_next    = TIMER_WIDTH'(pulse_low_ticks);
                    level_next      = 1'b0;
                    phase_high_next = 1'b0;
                    if (pulses_inc >= PULSE_CNT_W'(pulses_per_half_cycle)) begin
                        armed_next  = 1'b0;
                        pulses_next = PULSES_STOPPED;
                    end
                end
            end
        end
    end

    // Commit gate state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg      <= '0;
            compare_reg    <= '0;
            armed_reg      <= 1'b0;
            phase_high_reg <= 1'b0;
            level_reg      <= 1'b0;
            pulses_reg     <= '0;
        end else if (step.fire) begin
            timer_reg      <= timer_next;
            compare_reg    <= compare_next;
            armed_reg      <= armed_next;
            phase_high_reg <= phase_high_next;
            level_reg      <= level_next;
            pulses_reg     <= pulses_next;
        end
    end

    assign stat_next.level  = level_next;
    assign stat_next.pulses = pulses_next;

    // Checks
    a_pulses_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pulses_reg <= PULSES_STOPPED)
        else $error("gate pulse counter out of range");

    a_stop_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (step.fire && !step.crossing && event_hit && phase_high_reg
         && pulses_next == PULSES_STOPPED) |=> !armed_reg)
        else $error("stopped train left gate armed");

    a_stopped_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pulses_reg == PULSES_STOPPED |-> !phase_high_reg && !level_reg)
        else $error("gate active after the train stopped");

endmodule

/* rtl/trpf_servo.sv */
// Servo timer: servo pulse width and sticky stop handling.
module trpf_servo import trpf_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  trpf_step_t         step,
    input  logic [TICKS_W-1:0] servo_width,
    output logic               level_next
);

    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [TIMER_WIDTH-1:0] compare_reg, compare_next;
    logic                   armed_reg, armed_next;
    logic                   pending_reg, pending_next;
    logic                   level_reg;

    logic [TIMER_WIDTH-1:0] timer_inc;
    logic                   pend_now;

    assign timer_inc = timer_reg + 1'b1;
    assign pend_now  = pending_reg || (armed_reg && (timer_inc == compare_reg));

    // Compute next servo state for one transaction
    always_comb begin
        timer_next   = timer_reg;
        compare_next = compare_reg;
        armed_next   = armed_reg;
        pending_next = pending_reg;
        level_next   = level_reg;
        if (step.crossing) begin
            level_next   = 1'b1;
            timer_next   = '0;
            compare_next = TIMER_WIDTH'(servo_width);
            armed_next   = 1'b1;
            pending_next = 1'b0;
        end else begin
            timer_next   = timer_inc;
            pending_next = pend_now;
            // Drop the pulse once a match is pending and stop is allowed
            if (pend_now && step.stop_ok) begin
                armed_next   = 1'b0;
                pending_next = 1'b0;
                level_next   = 1'b0;
            end
        end
    end

    // Commit servo state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg   <= '0;
            compare_reg <= '0;
            armed_reg   <= 1'b0;
            pending_reg <= 1'b0;
            level_reg   <= 1'b0;
        end else if (step.fire) begin
            timer_reg   <= timer_next;
            compare_reg <= compare_next;
            armed_reg   <= armed_next;
            pending_reg <= pending_next;
            level_reg   <= level_next;
        end
    end

    // Checks
    a_pending_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> armed_reg)
        else $error("servo match pending while disarmed");

    a_cross_raises: assert property (@(posedge aclk) disable iff (!aresetn)
        (step.fire && step.crossing) |=> level_reg && armed_reg && !pending_reg)
        else $error("crossing did not restart servo pulse");

    a_stop_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (step.fire && !step.crossing && pend_now && step.stop_ok) |=> !level_reg)
        else $error("servo stop did not drop output");

endmodule

/* rtl/triac_phase_fire_controller.sv */
// Top level: input register, gate and servo timers, result register.
//
//  channel  prefix  handshake           payload
//  input    s_      s_valid / s_ready   action, phase_delay, servo_width,
//                                       firing_enable, servo_stop_allowed
//  result   m_      m_valid / m_ready   gate_out, servo_out, pulses_done, half_cycles
//  config   cfg_    cfg_wr_en           cfg_index, cfg_wdata
//
// One transaction per cycle while the result channel is not stalled; a result is presented
// after the input register, then the single-pass state update into the result register.
// Synchronous active-low reset clears all timers, flags and counters and loads
// the register defaults. A stalled result holds the result register and the
// input register; s_ready stays high while either stage can move.
module triac_phase_fire_controller import trpf_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_action,
    input  logic [TICKS_W-1:0]     s_phase_delay,
    input  logic [TICKS_W-1:0]     s_servo_width,
    input  logic                   s_firing_enable,
    input  logic                   s_servo_stop_allowed,
    // Result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_gate_out,
    output logic                   m_servo_out,
    output logic [PULSE_CNT_W-1:0] m_pulses_done,
    output logic [CROSS_CNT_W-1:0] m_half_cycles
);

    // Configuration registers
    logic [TICKS_W-1:0] pulse_high_reg;
    logic [TICKS_W-1:0] pulse_low_reg;
    logic [PPC_W-1:0]   pulses_per_reg;

    // Input stage
    logic               in_valid_reg;
    logic               in_action_reg;
    logic [TICKS_W-1:0] in_delay_reg;
    logic [TICKS_W-1:0] in_width_reg;
    logic               in_enable_reg;
    logic               in_stop_reg;

    // Result stage
    logic                   out_valid_reg;
    logic                   out_gate_reg;
    logic                   out_servo_reg;
    logic [PULSE_CNT_W-1:0] out_pulses_reg;
    logic [CROSS_CNT_W-1:0] out_cross_reg;

    logic [CROSS_CNT_W-1:0] crossing_count_reg, crossing_count_next;

    logic            advance;
    trpf_step_t      step;
    trpf_gate_stat_t gate_stat;
    logic            servo_level_next;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign step.fire     = in_valid_reg && advance;
    assign step.crossing = (trpf_action_t'(in_action_reg) == ACT_CROSSING);
    assign step.enable   = in_enable_reg;
    assign step.stop_ok  = in_stop_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_high_reg <= PULSE_HIGH_RST;
            pulse_low_reg  <= PULSE_LOW_RST;
            pulses_per_reg <= PULSES_PER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PULSE_HIGH: pulse_high_reg <= cfg_wdata;
                CFG_PULSE_LOW:  pulse_low_reg  <= cfg_wdata;
                CFG_PULSES_PER: pulses_per_reg <= cfg_wdata[PPC_W-1:0];
                default:        ;
            endcase
        end
    end

    // Capture input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_delay_reg  <= s_phase_delay;
            in_width_reg  <= s_servo_width;
            in_enable_reg <= s_firing_enable;
            in_stop_reg   <= s_servo_stop_allowed;
        end
    end

    trpf_gate #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_gate (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .step                  (step),
        .phase_delay           (in_delay_reg),
        .pulse_high_ticks      (pulse_high_reg),
        .pulse_low_ticks       (pulse_low_reg),
        .pulses_per_half_cycle (pulses_per_reg),
        .stat_next             (gate_stat)
    );

    trpf_servo #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_servo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .servo_width (in_width_reg),
        .level_next  (servo_level_next)
    );

    // Count zero crossings
    assign crossing_count_next = step.crossing ? crossing_count_reg + 1'b1
                                               : crossing_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crossing_count_reg <= '0;
        end else if (step.fire) begin
            crossing_count_reg <= crossing_count_next;
        end
    end

    // Hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.fire) begin
            out_gate_reg   <= gate_stat.level;
            out_servo_reg  <= servo_level_next;
            out_pulses_reg <= gate_stat.pulses;
            out_cross_reg  <= crossing_count_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_gate_out    = out_gate_reg;
    assign m_servo_out   = out_servo_reg;
    assign m_pulses_done = out_pulses_reg;
    assign m_half_cycles = out_cross_reg;

    // Checks
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step.fire |=> out_valid_reg)
        else $error("committed transaction produced no result");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (step.fire && step.crossing) |=>
            crossing_count_reg == $past(crossing_count_reg) + 1'b1)
        else $error("crossing count did not advance");

    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_cross_reg == crossing_count_reg || in_valid_reg)
        else $error("result crossing count out of step");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the triac phase fire controller.
module tb;
    import trpf_pkg::*;

    localparam int TW           = TIMER_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1950;
    localparam int MAX_WAIT     = 12;
    localparam int STALL_LIMIT  = 1000;
    localparam int SPAN_CAP     = 120;

    typedef struct packed {
        trpf_action_t       action;
        logic [TICKS_W-1:0] phase_delay;
        logic [TICKS_W-1:0] servo_width;
        logic               firing_enable;
        logic               servo_stop_allowed;
    } fire_item_t;

    typedef struct packed {
        logic                   gate_out;
        logic                   servo_out;
        logic [PULSE_CNT_W-1:0] pulses_done;
        logic [CROSS_CNT_W-1:0] half_cycles;
    } fire_levels_t;

    // Track gate and servo levels per transaction and compare them with the block
    class fire_level_tracker;
        logic [TICKS_W-1:0]     hi_ticks;
        logic [TICKS_W-1:0]     lo_ticks;
        logic [PPC_W-1:0]       pulses_per;
        logic [TW-1:0]          dly_timer;
        logic [TW-1:0]          dly_compare;
        logic [TW-1:0]          srv_timer;
        logic [TW-1:0]          srv_compare;
        logic                   fire_armed;
        logic                   in_pulse;
        logic                   gate_q;
        logic                   srv_armed;
        logic                   srv_hit_held;
        logic                   srv_q;
        logic [PULSE_CNT_W-1:0] pulse_num;
        logic [CROSS_CNT_W-1:0] zc_count;
        fire_levels_t           expected_levels[$];
        int                     failures;

        function new();
            hi_ticks     = PULSE_HIGH_RST;
            lo_ticks     = PULSE_LOW_RST;
            pulses_per   = PULSES_PER_RST;
            dly_timer    = '0;
            dly_compare  = '0;
            srv_timer    = '0;
            srv_compare  = '0;
            fire_armed   = 1'b0;
            in_pulse     = 1'b0;
            gate_q       = 1'b0;
            srv_armed    = 1'b0;
            srv_hit_held = 1'b0;
            srv_q        = 1'b0;
            pulse_num    = '0;
            zc_count     = '0;
            failures     = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PULSE_HIGH: hi_ticks = data;
                CFG_PULSE_LOW:  lo_ticks = data;
                CFG_PULSES_PER: pulses_per = data[PPC_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_step(fire_item_t it);
            fire_levels_t lv;
            if (it.action == ACT_CROSSING) begin
                // restart both timers, latch delay and width, raise the servo
                if (pulse_num == PULSES_STOPPED)
                    pulse_num = '0;
                in_pulse     = 1'b0;
                zc_count     = zc_count + 1'b1;
                dly_timer    = '0;
                dly_compare  = it.phase_delay;
                srv_q        = 1'b1;
                srv_timer    = '0;
                srv_compare  = it.servo_width;
                if (it.firing_enable)
                    fire_armed = 1'b1;
                srv_armed    = 1'b1;
                srv_hit_held = 1'b0;
            end else begin
                dly_timer = dly_timer + 1'b1;
                srv_timer = srv_timer + 1'b1;
                // gate compare hit: start a pulse, or end one and count it
                if (fire_armed && dly_timer == dly_compare) begin
                    if (!in_pulse) begin
                        if (pulse_num < PULSES_STOPPED) begin
                            if (it.firing_enable)
                                gate_q = 1'b1;
                            in_pulse    = 1'b1;
                            dly_timer   = '0;
                            dly_compare = hi_ticks;
                        end
                    end else begin
                        pulse_num   = pulse_num + 1'b1;
                        dly_timer   = '0;
                        dly_compare = lo_ticks;
                        gate_q      = 1'b0;
                        in_pulse    = 1'b0;
                        if (pulse_num >= PULSE_CNT_W'(pulses_per)) begin
                            fire_armed = 1'b0;
                            pulse_num  = PULSES_STOPPED;
                        end
                    end
                end
                // hold a servo match until a tick allows the stop
                if (srv_armed && srv_timer == srv_compare)
                    srv_hit_held = 1'b1;
                if (srv_hit_held && it.servo_stop_allowed) begin
                    srv_armed    = 1'b0;
                    srv_hit_held = 1'b0;
                    srv_q        = 1'b0;
                end
            end
            lv = '{gate_q, srv_q, pulse_num, zc_count};
            expected_levels.push_back(lv);
        endfunction

        function void check_levels(fire_levels_t got);
            fire_levels_t want;
            if (expected_levels.size() == 0) begin
                $error("unexpected result: gate_out %0d servo_out %0d pulses_done %0d half_cycles %0d",
                       got.gate_out, got.servo_out, got.pulses_done, got.half_cycles);
                failures++;
                return;
            end
            want = expected_levels.pop_front();
            if (got.gate_out !== want.gate_out) begin
                $error("gate_out: expected %0d, actual %0d", want.gate_out, got.gate_out);
                failures++;
            end
            if (got.servo_out !== want.servo_out) begin
                $error("servo_out: expected %0d, actual %0d", want.servo_out, got.servo_out);
                failures++;
            end
            if (got.pulses_done !== want.pulses_done) begin
                $error("pulses_done: expected %0d, actual %0d", want.pulses_done, got.pulses_done);
                failures++;
            end
            if (got.half_cycles !== want.half_cycles) begin
                $error("half_cycles: expected %0d, actual %0d", want.half_cycles, got.half_cycles);
                failures++;
            end
        endfunction
    endclass

    logic                   aclk                 = 1'b0;
    logic                   aresetn              = 1'b0;
    logic                   cfg_wr_en            = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index            = CFG_PULSE_HIGH;
    logic [CFG_DATA_W-1:0]  cfg_wdata            = '0;
    logic                   s_valid              = 1'b0;
    logic                   s_ready;
    logic                   s_action             = ACT_TICK;
    logic [TICKS_W-1:0]     s_phase_delay        = '0;
    logic [TICKS_W-1:0]     s_servo_width        = '0;
    logic                   s_firing_enable      = 1'b0;
    logic                   s_servo_stop_allowed = 1'b0;
    logic                   m_valid;
    logic                   m_ready              = 1'b0;
    logic                   m_gate_out;
    logic                   m_servo_out;
    logic [PULSE_CNT_W-1:0] m_pulses_done;
    logic [CROSS_CNT_W-1:0] m_half_cycles;

    fire_level_tracker tracker = new();

    int                 items_sent  = 0;
    int                 stall_count = 0;
    bit                 tx_steady   = 1'b0;
    bit                 rx_steady   = 1'b0;
    logic [TICKS_W-1:0] cur_hi      = PULSE_HIGH_RST;
    logic [TICKS_W-1:0] cur_lo      = PULSE_LOW_RST;
    logic [PPC_W-1:0]   cur_ppc     = PULSES_PER_RST;

    triac_phase_fire_controller #(
        .TIMER_WIDTH(TIMER_WIDTH_DEF)
    ) u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_action             (s_action),
        .s_phase_delay        (s_phase_delay),
        .s_servo_width        (s_servo_width),
        .s_firing_enable      (s_firing_enable),
        .s_servo_stop_allowed (s_servo_stop_allowed),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_gate_out           (m_gate_out),
        .m_servo_out          (m_servo_out),
        .m_pulses_done        (m_pulses_done),
        .m_half_cycles        (m_half_cycles)
    );

    // Run the clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else if (stall_count == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function automatic fire_item_t mk_item(trpf_action_t act, logic [TICKS_W-1:0] dly,
                                           logic [TICKS_W-1:0] wid, logic en, logic stop);
        fire_item_t it;
        it.action             = act;
        it.phase_delay        = dly;
        it.servo_width        = wid;
        it.firing_enable      = en;
        it.servo_stop_allowed = stop;
        return it;
    endfunction

    // Mostly ticks with random fields (delay and width are ignored on ticks); now and then a stray crossing
    function automatic fire_item_t pick_tick();
        return mk_item(($urandom_range(0, 11) == 0) ? ACT_CROSSING : ACT_TICK,
                       16'($urandom), 16'($urandom),
                       $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
    endfunction

    // Present one transaction after a random gap and hold it until accepted
    task automatic send_item(input fire_item_t it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_action             <= it.action;
        s_phase_delay        <= it.phase_delay;
        s_servo_width        <= it.servo_width;
        s_firing_enable      <= it.firing_enable;
        s_servo_stop_allowed <= it.servo_stop_allowed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.accept_step(it);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result is back
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.expected_levels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three timing registers on back-to-back cycles
    task automatic load_timing(input logic [CFG_DATA_W-1:0] hi, input logic [CFG_DATA_W-1:0] lo,
                               input logic [PPC_W-1:0] ppc);
        logic [CFG_INDEX_W-1:0] regs[3];
        logic [CFG_DATA_W-1:0]  vals[3];
        regs = '{CFG_PULSE_HIGH, CFG_PULSE_LOW, CFG_PULSES_PER};
        vals = '{hi, lo, CFG_DATA_W'(ppc)};
        cfg_wr_en <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            tracker.write_register(regs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
        cur_hi  = hi;
        cur_lo  = lo;
        cur_ppc = ppc;
    endtask

    // One crossing, then about enough ticks to play out the pulse train, at most SPAN_CAP
    task automatic run_half_cycle();
        fire_item_t zc;
        int         span;
        int         pulses;
        zc = mk_item(ACT_CROSSING,
                     ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12)),
                     ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                     $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)));
        send_item(zc);
        pulses = (cur_ppc == 0) ? 1 : int'(cur_ppc);
        span = int'(zc.phase_delay) + pulses * (int'(cur_hi) + int'(cur_lo))
             + $urandom_range(0, 6);
        if (span > SPAN_CAP)
            span = SPAN_CAP;
        // cut some trains short
        if ($urandom_range(0, 5) == 0)
            span = $urandom_range(1, span);
        repeat (span) send_item(pick_tick());
    endtask

    // Accept results after random stalls and check each one
    initial begin : result_sink
        int           stall;
        fire_levels_t got;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got = '{m_gate_out, m_servo_out, m_pulses_done, m_half_cycles};
            tracker.check_levels(got);
        end
    end

    initial begin : stimulus
        int first_random;
        int phase;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: default timing, sticky servo match, crossing during a train
        send_item(mk_item(ACT_TICK,     16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        send_item(mk_item(ACT_CROSSING, 16'd1,    16'd1,    1'b1, 1'b0));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b0));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b0, 1'b0));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b0, 1'b1));
        send_item(mk_item(ACT_CROSSING, 16'd2,    16'd0,    1'b0, 1'b1));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b1));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b1));
        send_item(mk_item(ACT_CROSSING, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        send_item(mk_item(ACT_TICK,     16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        settle();

        // Directed: zero pulse count, zero delay, crossing without enable
        load_timing(16'd1, 16'd1, 2'd0);
        send_item(mk_item(ACT_CROSSING, 16'd0,    16'd3,    1'b1, 1'b0));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b0));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b0));
        send_item(mk_item(ACT_CROSSING, 16'd1,    16'd2,    1'b1, 1'b0));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b0));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b0, 1'b0));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b0));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b1));
        send_item(mk_item(ACT_CROSSING, 16'd1,    16'd1,    1'b0, 1'b1));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b1));
        send_item(mk_item(ACT_TICK,     16'd0,    16'd0,    1'b1, 1'b1));

        // Random phases: new timing each phase, extremes first
        first_random = items_sent;
        phase = 0;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            settle();
            case (phase)
                0: load_timing(16'd1, 16'd1, 2'd1);
                1: load_timing(16'hFFFF, 16'd1, 2'd0);
                2: load_timing(16'd1, 16'hFFFF, 2'd2);
                3: load_timing(16'd2, 16'd3, 2'd3);
                default: load_timing(
                    ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                    ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                    PPC_W'($urandom_range(0, 3)));
            endcase
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 6)) run_half_cycle();
            phase++;
        end

        settle();
        repeat (20) @(posedge aclk);
        if (tracker.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/trpf_pkg.sv
rtl/trpf_gate.sv
rtl/trpf_servo.sv
rtl/triac_phase_fire_controller.sv
tb/tb.sv
